FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the detector.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/cdsd_pkg.sv
// Shared types, constants and helpers of the charge/discharge state detector.
// No dependencies; imported by every module of the block.
package cdsd_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] COUNT_CAP = 16'd60000;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CHARGE_ON     = 3'd0,
        REG_CHARGE_OFF    = 3'd1,
        REG_DISCHARGE_ON  = 3'd2,
        REG_DISCHARGE_OFF = 3'd3,
        REG_CONFIRM       = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CHG  = 2'd1,
        MODE_DCHG = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [15:0] current_sample;
        logic               charge_switch_on;
        logic               discharge_switch_on;
        logic               charger_present;
    } in_item_t;

    typedef struct packed {
        logic [1:0] pack_mode;
        logic       charging_flag;
        logic       discharging_flag;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] charge_on_level;
        logic signed [15:0] charge_off_level;
        logic signed [15:0] discharge_on_level;
        logic signed [15:0] discharge_off_level;
        logic [14:0]        confirm_ticks;
    } cfg_t;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c < COUNT_CAP) ? c + 16'd1 : c;
    endfunction

endpackage

FILE: rtl/charge_discharge_state_detector_core.sv
// Charge/discharge state detector: a transferred sample is registered in the input register,
// then in the state/result register. Throughput one sample per cycle while out_ready keeps up.
// The input stage stalls only while a result waits on out_ready.
// Reset (rst_n, async, active low) clears counters, flags, mode (idle) and valids,
// and loads the level and confirmation registers with their defaults.
module charge_discharge_state_detector_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cdsd_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cdsd_pkg::out_item_t          out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cdsd_pkg::DATA_W-1:0]  pwdata,
    output logic [cdsd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import cdsd_pkg::*;

`include "assert_macros.svh"

    cfg_t     cfg;
    logic     take;
    logic     stage_valid;
    in_item_t stage_data;

    cdsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cdsd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    cdsd_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    `ASSERT_IMPLIES(a_chg_mode, clk, rst_n,
        out_valid && out_data.charging_flag && !out_data.discharging_flag,
        out_data.pack_mode == MODE_CHG)
    `ASSERT_IMPLIES(a_dchg_mode, clk, rst_n,
        out_valid && !out_data.charging_flag && out_data.discharging_flag,
        out_data.pack_mode == MODE_DCHG)
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n,
        !in_ready,
        stage_valid && out_valid && !out_ready)
    `ASSERT_NEXT(a_take_result, clk, rst_n,
        take,
        out_valid)

endmodule

FILE: rtl/cdsd_cfg.sv
// APB-style configuration registers of the detector.
// Depends on cdsd_pkg for the register map and the cfg_t bundle.
module cdsd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cdsd_pkg::DATA_W-1:0]  pwdata,
    output logic [cdsd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output cdsd_pkg::cfg_t               cfg
);
    import cdsd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_on_level     <= 16'sd100;
            cfg_reg.charge_off_level    <= 16'sd50;
            cfg_reg.discharge_on_level  <= -16'sd100;
            cfg_reg.discharge_off_level <= -16'sd50;
            cfg_reg.confirm_ticks       <= 15'd15;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CHARGE_ON:     cfg_reg.charge_on_level     <= pwdata[15:0];
                REG_CHARGE_OFF:    cfg_reg.charge_off_level    <= pwdata[15:0];
                REG_DISCHARGE_ON:  cfg_reg.discharge_on_level  <= pwdata[15:0];
                REG_DISCHARGE_OFF: cfg_reg.discharge_off_level <= pwdata[15:0];
                REG_CONFIRM:       cfg_reg.confirm_ticks       <= pwdata[14:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CHARGE_ON:     prdata = {{16{cfg_reg.charge_on_level[15]}},
                                         cfg_reg.charge_on_level};
            REG_CHARGE_OFF:    prdata = {{16{cfg_reg.charge_off_level[15]}},
                                         cfg_reg.charge_off_level};
            REG_DISCHARGE_ON:  prdata = {{16{cfg_reg.discharge_on_level[15]}},
                                         cfg_reg.discharge_on_level};
            REG_DISCHARGE_OFF: prdata = {{16{cfg_reg.discharge_off_level[15]}},
                                         cfg_reg.discharge_off_level};
            REG_CONFIRM:       prdata = {17'd0, cfg_reg.confirm_ticks};
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: rtl/cdsd_in_stage.sv
// Input register of the detector: captures one sample transfer per cycle while in_ready is high.
// Depends on cdsd_pkg for the input item type.
module cdsd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cdsd_pkg::in_item_t in_data,
    input  logic               take,
    output logic               stage_valid,
    output cdsd_pkg::in_item_t stage_data
);
    import cdsd_pkg::*;

    logic     valid_reg;
    in_item_t data_reg;

    assign in_ready    = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: rtl/cdsd_eval.sv
// Run counters, hysteresis flags and pack mode; the state doubles as result register.
// Depends on cdsd_pkg for types, the count cap and the saturating bump.
module cdsd_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  cdsd_pkg::cfg_t      cfg,
    input  logic                stage_valid,
    input  cdsd_pkg::in_item_t  stage_data,
    output logic                take,
    output logic                out_valid,
    input  logic                out_ready,
    output cdsd_pkg::out_item_t out_data
);
    import cdsd_pkg::*;

    logic [CNT_W-1:0] charge_run_reg, charge_run_next;
    logic [CNT_W-1:0] discharge_run_reg, discharge_run_next;
    logic [CNT_W-1:0] idle_run_reg, idle_run_next;
    logic             charge_flag_reg, charge_flag_next;
    logic             discharge_flag_reg, discharge_flag_next;
    mode_t            mode_reg, mode_next;
    logic             out_valid_reg;
    logic             chg_cond, dchg_cond;
    logic [CNT_W-1:0] confirm_ext, idle_limit;

    assign take = stage_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        chg_cond  = (stage_data.current_sample >= cfg.charge_on_level)
                    && stage_data.charge_switch_on && stage_data.charger_present;
        dchg_cond = (stage_data.current_sample <= cfg.discharge_on_level)
                    && stage_data.discharge_switch_on;
        confirm_ext = {1'b0, cfg.confirm_ticks};
        idle_limit  = {cfg.confirm_ticks, 1'b0};

        charge_run_next    = chg_cond ? bump(charge_run_reg) : '0;
        discharge_run_next = dchg_cond ? bump(discharge_run_reg) : '0;

        if (dchg_cond)
            idle_run_next = '0;
        else if (chg_cond)
            idle_run_next = bump('0);
        else
            idle_run_next = bump(bump(idle_run_reg));

        if (charge_run_next >= confirm_ext)
            charge_flag_next = 1'b1;
        else if (stage_data.current_sample <= cfg.charge_off_level)
            charge_flag_next = 1'b0;
        else
            charge_flag_next = charge_flag_reg;

        if (discharge_run_next >= confirm_ext)
            discharge_flag_next = 1'b1;
        else if (stage_data.current_sample >= cfg.discharge_off_level)
            discharge_flag_next = 1'b0;
        else
            discharge_flag_next = discharge_flag_reg;

        mode_next = mode_reg;
        if (discharge_flag_next && !charge_flag_next)
            mode_next = MODE_DCHG;
        else if (!discharge_flag_next && charge_flag_next)
            mode_next = MODE_CHG;
        else if (!discharge_flag_next && !charge_flag_next && (idle_run_next >= idle_limit))
            mode_next = MODE_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_run_reg     <= '0;
            discharge_run_reg  <= '0;
            idle_run_reg       <= '0;
            charge_flag_reg    <= 1'b0;
            discharge_flag_reg <= 1'b0;
            mode_reg           <= MODE_IDLE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                charge_run_reg     <= charge_run_next;
                discharge_run_reg  <= discharge_run_next;
                idle_run_reg       <= idle_run_next;
                charge_flag_reg    <= charge_flag_next;
                discharge_flag_reg <= discharge_flag_next;
                mode_reg           <= mode_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid                 = out_valid_reg;
    assign out_data.pack_mode        = mode_reg;
    assign out_data.charging_flag    = charge_flag_reg;
    assign out_data.discharging_flag = discharge_flag_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for charge_discharge_state_detector_core: random and directed current
// samples over valid/ready, APB register writes between phases, scoreboarded pack mode and flags.
// Depends on cdsd_pkg and the core RTL only.
module tb_top;
    import cdsd_pkg::*;

    typedef enum {SEG_CHARGE, SEG_DISCHARGE, SEG_IDLE, SEG_NOISE} seg_kind_t;

    localparam logic [15:0] RUN_CAP = 16'd60000;
    localparam logic [2:0] UNUSED_REG_INDEX = 3'd5;
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int SOAK_CHARGE = 24;
    localparam int SOAK_IDLE = 24;
    localparam int SETTLE_CYCLES = 8;

    class pack_mode_scoreboard;
        logic signed [15:0] chg_on_lvl;
        logic signed [15:0] chg_off_lvl;
        logic signed [15:0] dchg_on_lvl;
        logic signed [15:0] dchg_off_lvl;
        logic [14:0] confirm_cnt;
        logic [15:0] chg_run;
        logic [15:0] dchg_run;
        logic [15:0] idle_run;
        logic chg_flag;
        logic dchg_flag;
        mode_t mode;
        out_item_t expected_modes[$];
        int failures;

        function new();
            chg_on_lvl = 16'sd100;
            chg_off_lvl = 16'sd50;
            dchg_on_lvl = -16'sd100;
            dchg_off_lvl = -16'sd50;
            confirm_cnt = 15'd15;
            chg_run = '0;
            dchg_run = '0;
            idle_run = '0;
            chg_flag = 1'b0;
            dchg_flag = 1'b0;
            mode = MODE_IDLE;
            failures = 0;
        endfunction

        function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            case (addr[ADDR_W-1:2])
                REG_CHARGE_ON:     chg_on_lvl = data[15:0];
                REG_CHARGE_OFF:    chg_off_lvl = data[15:0];
                REG_DISCHARGE_ON:  dchg_on_lvl = data[15:0];
                REG_DISCHARGE_OFF: dchg_off_lvl = data[15:0];
                REG_CONFIRM:       confirm_cnt = data[14:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] sat_inc(logic [15:0] c);
            return (c < RUN_CAP) ? c + 16'd1 : c;
        endfunction

        function void note_sample(in_item_t s);
            logic signed [15:0] cur;
            logic chg_cond;
            logic dchg_cond;
            out_item_t r;
            cur = $signed(s.current_sample);
            chg_cond = (cur >= chg_on_lvl) && s.charge_switch_on && s.charger_present;
            dchg_cond = (cur <= dchg_on_lvl) && s.discharge_switch_on;

            // charge branch first, then discharge; each touches idle_run
            if (chg_cond) begin
                idle_run = '0;
                chg_run = sat_inc(chg_run);
            end else begin
                chg_run = '0;
                idle_run = sat_inc(idle_run);
            end
            if (dchg_cond) begin
                idle_run = '0;
                dchg_run = sat_inc(dchg_run);
            end else begin
                dchg_run = '0;
                idle_run = sat_inc(idle_run);
            end

            if (chg_run >= {1'b0, confirm_cnt})
                chg_flag = 1'b1;
            else if (cur <= chg_off_lvl)
                chg_flag = 1'b0;
            if (dchg_run >= {1'b0, confirm_cnt})
                dchg_flag = 1'b1;
            else if (cur >= dchg_off_lvl)
                dchg_flag = 1'b0;

            if (dchg_flag && !chg_flag)
                mode = MODE_DCHG;
            else if (!dchg_flag && chg_flag)
                mode = MODE_CHG;
            else if (!dchg_flag && !chg_flag && idle_run >= {confirm_cnt, 1'b0})
                mode = MODE_IDLE;

            r.pack_mode = mode;
            r.charging_flag = chg_flag;
            r.discharging_flag = dchg_flag;
            expected_modes.push_back(r);
        endfunction

        function void check_mode(out_item_t got);
            out_item_t want;
            if (expected_modes.size() == 0) begin
                $error("result with no sample pending: pack_mode %0d", got.pack_mode);
                failures++;
                return;
            end
            want = expected_modes.pop_front();
            if (got.pack_mode !== want.pack_mode) begin
                $error("pack_mode: expected %0d, got %0d", want.pack_mode, got.pack_mode);
                failures++;
            end
            if (got.charging_flag !== want.charging_flag) begin
                $error("charging_flag: expected %0d, got %0d",
                       want.charging_flag, got.charging_flag);
                failures++;
            end
            if (got.discharging_flag !== want.discharging_flag) begin
                $error("discharging_flag: expected %0d, got %0d",
                       want.discharging_flag, got.discharging_flag);
                failures++;
            end
        endfunction

        function int pending();
            return expected_modes.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    bit hurry;
    bit in_calm;
    bit out_calm;
    int quiet_cycles;
    pack_mode_scoreboard sb = new();

    charge_discharge_state_detector_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_sample(in_data);
        if (out_valid && out_ready)
            sb.check_mode(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 7) == 0)
            calm = !calm;
        return (calm || hurry) ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic int pick(int lo, int hi);
        int r;
        if (hi <= lo)
            return lo;
        r = $urandom_range(0, 3);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic in_item_t make_sample(seg_kind_t kind);
        in_item_t s;
        int lo_mid;
        int hi_mid;
        s.current_sample = 16'($urandom);
        s.charge_switch_on = 1'($urandom_range(0, 1));
        s.discharge_switch_on = 1'($urandom_range(0, 1));
        s.charger_present = 1'($urandom_range(0, 1));
        case (kind)
            SEG_CHARGE:
            begin
                s.current_sample = 16'(pick(sb.chg_on_lvl, 32767));
                s.charge_switch_on = 1'b1;
                s.charger_present = 1'b1;
            end
            SEG_DISCHARGE:
            begin
                s.current_sample = 16'(pick(-32768, sb.dchg_on_lvl));
                s.discharge_switch_on = 1'b1;
            end
            SEG_IDLE:
            begin
                lo_mid = sb.dchg_on_lvl + 1;
                hi_mid = sb.chg_on_lvl - 1;
                if (lo_mid <= hi_mid)
                    s.current_sample = 16'(pick(lo_mid, hi_mid));
                else
                begin
                    s.charge_switch_on = 1'b0;
                    s.discharge_switch_on = 1'b0;
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_sample(in_item_t s);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= s;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_n(int cur, bit csw, bit dsw, bit plug, int n);
        in_item_t s;
        s.current_sample = 16'(cur);
        s.charge_switch_on = csw;
        s.discharge_switch_on = dsw;
        s.charger_present = plug;
        repeat (n) send_sample(s);
    endtask

    // leaves psel high; the caller drops it after the last write
    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.write_reg(addr, data);
        @(negedge clk);
    endtask

    task automatic load_config(int c_on, int c_off, int d_on, int d_off, int confirm);
        apb_write({REG_CHARGE_ON, 2'b00}, 32'(c_on));
        apb_write({REG_CHARGE_OFF, 2'b00}, 32'(c_off));
        apb_write({REG_DISCHARGE_ON, 2'b00}, 32'(d_on));
        apb_write({REG_DISCHARGE_OFF, 2'b00}, 32'(d_off));
        apb_write({REG_CONFIRM, 2'b00}, 32'(confirm));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_config();
        int c_on;
        int c_off;
        int d_on;
        int d_off;
        int conf;
        if ($urandom_range(0, 3) == 0)
        begin
            c_on = pick(-32768, 32767);
            c_off = pick(-32768, 32767);
            d_on = pick(-32768, 32767);
            d_off = pick(-32768, 32767);
        end
        else
        begin
            c_on = pick(0, 3000);
            c_off = c_on - pick(0, 1000);
            d_on = -pick(0, 3000);
            d_off = d_on + pick(0, 1000);
        end
        conf = ($urandom_range(0, 7) == 0) ? pick(0, 30000) : pick(0, 12);
        load_config(c_on, c_off, d_on, d_off, conf);
    endtask

    task automatic run_random_phase(int n_items);
        seg_kind_t kind;
        int r;
        int span;
        int len;
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 9);
            kind = (r < 3) ? SEG_CHARGE : (r < 6) ? SEG_DISCHARGE : (r < 9) ? SEG_IDLE : SEG_NOISE;
            span = 2 * sb.confirm_cnt + 4;
            if (span > 40)
                span = 40;
            len = $urandom_range(1, span);
            repeat (len)
            begin
                send_sample(make_sample(($urandom_range(0, 11) == 0) ? SEG_NOISE : kind));
                sent++;
            end
        end
    endtask

    // drop the input, then wait for every accepted sample to come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(out_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset levels: boundaries of each condition
        send_n(32767, 1, 1, 1, 1);
        send_n(-32768, 1, 1, 1, 1);
        send_n(0, 0, 0, 0, 1);
        send_n(100, 1, 0, 1, 1);
        send_n(99, 1, 1, 1, 1);
        send_n(-100, 0, 1, 0, 1);
        send_n(-99, 1, 1, 1, 1);
        send_n(100, 1, 1, 0, 1);
        send_n(-32768, 0, 1, 1, 1);
        drain();

        // write past the last register, then zero confirmation: both flags, mode holds
        apb_write({UNUSED_REG_INDEX, 2'b00}, $urandom);
        load_config(100, 50, -100, -50, 0);
        send_n(0, 0, 0, 0, 1);
        send_n(32767, 1, 0, 1, 1);
        send_n(-32768, 0, 1, 0, 1);
        drain();

        // short confirmation: set, hysteresis hold, idle confirm, discharge
        load_config(100, 50, -100, -50, 2);
        send_n(200, 1, 0, 1, 3);
        send_n(75, 0, 0, 1, 1);
        send_n(0, 0, 0, 0, 2);
        send_n(-200, 0, 1, 0, 3);
        send_n(-60, 0, 0, 0, 1);
        send_n(-50, 0, 0, 0, 1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            if (p == 0)
                load_config(-32768, 32767, 32767, -32768, 1);
            else if (p == 1)
                load_config(32767, -32768, -32768, 32767, 3);
            else
                random_config();
            run_random_phase(RANDOM_PER_PHASE);
        end

        // back-to-back charge run under a confirmation threshold of 30000, then idle
        drain();
        hurry = 1'b1;
        load_config(-32768, 32767, -100, -50, 30000);
        repeat (SOAK_CHARGE) send_sample(make_sample(SEG_CHARGE));
        repeat (SOAK_IDLE) send_sample(make_sample(SEG_IDLE));
        hurry = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
